// ===== sv/assert_macros.svh =====
// Assertion macros for the codec modules, used by the result register.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error(msg);

// Implication checked in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== sv/fbsc_pkg.sv =====
// Package for the frame byte stuffing codec: codes, register map and shared types.
package fbsc_pkg;

	localparam logic [7:0] DelimCode  = 8'h5A;
	localparam logic [7:0] EscCode    = 8'h50;
	localparam logic [7:0] EscOfDelim = 8'h0A;
	localparam logic [7:0] EscOfEsc   = 8'h05;

	localparam int ApbAddrW = 3;
	localparam logic RegMode = 1'b0;   // word index of the mode register

	localparam logic ModeStuff   = 1'b0;
	localparam logic ModeUnstuff = 1'b1;

	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        fend;
		logic [15:0] count;
	} res_t;

	typedef struct packed {
		logic [1:0]  n;
		res_t        r0;
		res_t        r1;
		logic        pend_next;
		logic [15:0] count_next;
	} dec_t;

endpackage

// ===== sv/fbsc_decode.sv =====
// Per-byte stuffing and unstuffing decision: up to two results and next state.
module fbsc_decode (
	input  logic              mode,
	input  logic              pend,
	input  logic [15:0]       count,
	input  logic [7:0]        in_byte,
	input  logic              frame_first,
	input  logic              frame_last,
	output fbsc_pkg::dec_t    dec
);

	logic [7:0]  b0;
	logic [7:0]  b1;
	logic        e0;
	logic        e1;
	logic [1:0]  n;
	logic        pend_n;
	logic        pend_eff;
	logic [15:0] base;

	always_comb begin
		b0       = fbsc_pkg::DelimCode;
		b1       = fbsc_pkg::DelimCode;
		e0       = 1'b0;
		e1       = 1'b0;
		n        = 2'd0;
		pend_n   = 1'b0;
		pend_eff = pend && (mode == fbsc_pkg::ModeUnstuff);
		if (frame_first) begin
			n = frame_last ? 2'd2 : 2'd1;
			e1 = 1'b1;
		end else if (frame_last) begin
			if (pend_eff) begin
				b0 = (in_byte == fbsc_pkg::EscOfDelim) ? fbsc_pkg::DelimCode : fbsc_pkg::EscCode;
				e1 = 1'b1;
				n  = 2'd2;
			end else begin
				e0 = 1'b1;
				n  = 2'd1;
			end
		end else if (pend_eff) begin
			// held escape: pair it with this byte, or flush it and carry on
			if (in_byte == fbsc_pkg::EscOfDelim) begin
				b0 = fbsc_pkg::DelimCode;
				n  = 2'd1;
			end else if (in_byte == fbsc_pkg::EscOfEsc) begin
				b0 = fbsc_pkg::EscCode;
				n  = 2'd1;
			end else if (in_byte == fbsc_pkg::EscCode) begin
				b0     = fbsc_pkg::EscCode;
				n      = 2'd1;
				pend_n = 1'b1;
			end else begin
				b0 = fbsc_pkg::EscCode;
				b1 = in_byte;
				n  = 2'd2;
			end
		end else if (mode == fbsc_pkg::ModeStuff) begin
			if (in_byte == fbsc_pkg::EscCode) begin
				b0 = fbsc_pkg::EscCode;
				b1 = fbsc_pkg::EscOfEsc;
				n  = 2'd2;
			end else if (in_byte == fbsc_pkg::DelimCode) begin
				b0 = fbsc_pkg::EscCode;
				b1 = fbsc_pkg::EscOfDelim;
				n  = 2'd2;
			end else begin
				b0 = in_byte;
				n  = 2'd1;
			end
		end else begin
			if (in_byte == fbsc_pkg::EscCode) begin
				pend_n = 1'b1;
			end else begin
				b0 = in_byte;
				n  = 2'd1;
			end
		end
	end

	assign base = frame_first ? 16'd0 : count;

	assign dec.n              = n;
	assign dec.r0.data        = b0;
	assign dec.r0.last        = (n == 2'd1);
	assign dec.r0.fend        = e0;
	assign dec.r0.count       = base + 16'd1;
	assign dec.r1.data        = b1;
	assign dec.r1.last        = 1'b1;
	assign dec.r1.fend        = e1;
	assign dec.r1.count       = base + 16'd2;
	assign dec.pend_next      = pend_n;
	assign dec.count_next     = base + {14'd0, n};

endmodule

// ===== sv/fbsc_outbuf.sv =====
// Two-slot result register that hands results out one per cycle while m_tready is high.
`include "assert_macros.svh"

module fbsc_outbuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load_req,
	input  fbsc_pkg::dec_t  dec,
	output logic            load_ok,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [23:0]     m_tdata,   // out_byte [7:0], out_count [23:8]
	output logic            m_tlast,
	output logic            m_tuser    // frame_end
);

	logic [1:0]     cnt_q;
	fbsc_pkg::res_t res0_q;
	fbsc_pkg::res_t res1_q;
	logic           pop;

	assign pop     = m_tvalid && m_tready;
	assign load_ok = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load_req && load_ok) begin
			cnt_q <= dec.n;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_req && load_ok) begin
			res0_q <= dec.r0;
			res1_q <= dec.r1;
		end else if (pop) begin
			res0_q <= res1_q;
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {res0_q.count, res0_q.data};
	assign m_tlast  = res0_q.last;
	assign m_tuser  = res0_q.fend;

	`ASSERT_ALWAYS(a_cnt_range, clk, arst_n, cnt_q != 2'd3, "result count out of range")
	`ASSERT_ALWAYS(a_pair_head, clk, arst_n, (cnt_q != 2'd2) || (!res0_q.last && res1_q.last),
		"run_last misplaced in result pair")
	`ASSERT_ALWAYS(a_end_last, clk, arst_n, !(m_tvalid && m_tuser) || m_tlast,
		"closing delimiter not marked last of its request")

endmodule

// ===== sv/frame_byte_stuffing_codec_top.sv =====
// Top level of the frame byte stuffing codec: input register, state, APB port.
//
//  channel   dir  fields
//  s_*       in   tdata = in_byte[7:0]; tuser = frame_first; tlast = frame_last
//  m_*       out  tdata = out_byte[7:0], out_count[23:8]; tuser = frame_end; tlast = run_last
//  apb       in   word 0 (byte address 0): mode, bit 0
//
// A request is registered, then decoded in one pass into zero to two results.
// Results leave one per cycle while m_tready is high;
// the single output port of the result register sets that rate.
// A new request is taken while results of the previous one still wait.
// Reset clears mode, the held escape, the byte count and all valid state.
// Stalls on m_tready back up through the result register to s_tready.
module frame_byte_stuffing_codec_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // in_byte [7:0]
	input  logic                          s_tlast,
	input  logic                          s_tuser,   // frame_first
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,   // out_byte [7:0], out_count [23:8]
	output logic                          m_tlast,
	output logic                          m_tuser,   // frame_end
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fbsc_pkg::ApbAddrW-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic           mode_q;
	logic           pend_q;
	logic [15:0]    count_q;
	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           first_s1;
	logic           last_s1;
	logic           load_ok;
	logic           step;
	fbsc_pkg::dec_t dec;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == fbsc_pkg::RegMode) ? {31'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= fbsc_pkg::ModeStuff;
		end else if (psel && penable && pwrite && pready && (paddr[2] == fbsc_pkg::RegMode)) begin
			mode_q <= pwdata[0];
		end
	end

	assign step     = valid_s1 && load_ok;
	assign s_tready = !valid_s1 || load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	// state moves when the decoded results enter the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			count_q <= 16'd0;
		end else if (step) begin
			pend_q  <= dec.pend_next;
			count_q <= dec.count_next;
		end
	end

	fbsc_decode u_decode (
		.mode        (mode_q),
		.pend        (pend_q),
		.count       (count_q),
		.in_byte     (byte_s1),
		.frame_first (first_s1),
		.frame_last  (last_s1),
		.dec         (dec)
	);

	fbsc_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load_req (valid_s1),
		.dec      (dec),
		.load_ok  (load_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== tb/fbsc_stream_checker.sv =====
// Checker for the byte stuffing codec: predicts every result from the accepted requests.
module fbsc_stream_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // in_byte [7:0]
	input  logic                            s_tlast,
	input  logic                            s_tuser,   // frame_first
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [23:0]                     m_tdata,   // out_byte [7:0], out_count [23:8]
	input  logic                            m_tlast,
	input  logic                            m_tuser,   // frame_end
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fbsc_pkg::ApbAddrW-1:0]   paddr,
	input  logic [31:0]                     pwdata,
	input  logic                            pready,
	output int                              fail_cnt,
	output int                              pending,
	output int                              req_cnt,
	output int                              res_cnt
);

	localparam int ModeAddrInt = 4 * fbsc_pkg::RegMode;
	localparam logic [fbsc_pkg::ApbAddrW-1:0] ModeAddr = ModeAddrInt[fbsc_pkg::ApbAddrW-1:0];

	fbsc_pkg::res_t due_bytes[$];
	logic           cur_mode;
	logic           held_esc;
	logic [15:0]    byte_cnt;
	fbsc_pkg::res_t step_r0;
	fbsc_pkg::res_t step_r1;
	int             step_n;

	function automatic void emit_byte(input logic [7:0] b, input logic fe);
		fbsc_pkg::res_t r;
		byte_cnt = byte_cnt + 16'd1;
		r.data   = b;
		r.last   = 1'b0;
		r.fend   = fe;
		r.count  = byte_cnt;
		if (step_n == 0)
			step_r0 = r;
		else
			step_r1 = r;
		step_n++;
	endfunction

	function automatic void stuff_predict(input logic [7:0] b, input logic first,
			input logic last);
		logic plain;
		plain  = 1'b1;
		step_n = 0;
		if (first) begin
			held_esc = 1'b0;
			byte_cnt = '0;
			emit_byte(fbsc_pkg::DelimCode, 1'b0);
			if (last)
				emit_byte(fbsc_pkg::DelimCode, 1'b1);
		end else begin
			if (cur_mode == fbsc_pkg::ModeStuff)
				held_esc = 1'b0;
			if (last) begin
				// a held escape is resolved by the last byte, which itself is dropped
				if (held_esc) begin
					emit_byte((b == fbsc_pkg::EscOfDelim) ? fbsc_pkg::DelimCode :
						fbsc_pkg::EscCode, 1'b0);
					held_esc = 1'b0;
				end
				emit_byte(fbsc_pkg::DelimCode, 1'b1);
			end else begin
				if (held_esc) begin
					held_esc = 1'b0;
					if (b == fbsc_pkg::EscOfDelim) begin
						emit_byte(fbsc_pkg::DelimCode, 1'b0);
						plain = 1'b0;
					end else if (b == fbsc_pkg::EscOfEsc) begin
						emit_byte(fbsc_pkg::EscCode, 1'b0);
						plain = 1'b0;
					end else begin
						emit_byte(fbsc_pkg::EscCode, 1'b0);
					end
				end
				if (plain) begin
					if (cur_mode == fbsc_pkg::ModeStuff) begin
						if (b == fbsc_pkg::EscCode) begin
							emit_byte(fbsc_pkg::EscCode, 1'b0);
							emit_byte(fbsc_pkg::EscOfEsc, 1'b0);
						end else if (b == fbsc_pkg::DelimCode) begin
							emit_byte(fbsc_pkg::EscCode, 1'b0);
							emit_byte(fbsc_pkg::EscOfDelim, 1'b0);
						end else begin
							emit_byte(b, 1'b0);
						end
					end else if (b == fbsc_pkg::EscCode) begin
						held_esc = 1'b1;
					end else begin
						emit_byte(b, 1'b0);
					end
				end
			end
		end
		if (step_n == 1)
			step_r0.last = 1'b1;
		else if (step_n == 2)
			step_r1.last = 1'b1;
		if (step_n > 0)
			due_bytes.push_back(step_r0);
		if (step_n > 1)
			due_bytes.push_back(step_r1);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fbsc_pkg::res_t want;
		if (!arst_n) begin
			due_bytes.delete();
			cur_mode = fbsc_pkg::ModeStuff;
			held_esc = 1'b0;
			byte_cnt = '0;
			fail_cnt = 0;
			req_cnt  = 0;
			res_cnt  = 0;
		end else begin
			// results first, so a result can never match an expectation made at the same edge
			if (m_tvalid && m_tready) begin
				res_cnt++;
				if (due_bytes.size() == 0) begin
					$error("result %h with nothing expected", m_tdata);
					fail_cnt++;
				end else begin
					want = due_bytes.pop_front();
					if (m_tdata[7:0] !== want.data) begin
						$error("out_byte: expected %h, got %h", want.data, m_tdata[7:0]);
						fail_cnt++;
					end
					if (m_tlast !== want.last) begin
						$error("run_last: expected %b, got %b", want.last, m_tlast);
						fail_cnt++;
					end
					if (m_tuser !== want.fend) begin
						$error("frame_end: expected %b, got %b", want.fend, m_tuser);
						fail_cnt++;
					end
					if (m_tdata[23:8] !== want.count) begin
						$error("out_count: expected %0d, got %0d", want.count, m_tdata[23:8]);
						fail_cnt++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				req_cnt++;
				stuff_predict(s_tdata, s_tuser, s_tlast);
			end
			if (psel && penable && pwrite && pready && paddr == ModeAddr)
				cur_mode = pwdata[0];
		end
		pending = due_bytes.size();
	end

endmodule

// ===== tb/tb_frame_byte_stuffing_codec_top.sv =====
// Testbench top for the byte stuffing codec: clock, reset, stimulus and verdict.
module tb_frame_byte_stuffing_codec_top;

	localparam int ModeAddrInt = 4 * fbsc_pkg::RegMode;
	localparam logic [fbsc_pkg::ApbAddrW-1:0] ModeAddr = ModeAddrInt[fbsc_pkg::ApbAddrW-1:0];
	localparam int HoldCycles  = 300;
	localparam int StallLimit  = 2000;
	localparam int IdlePct     = 26;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata = '0;
	logic                          s_tlast = 1'b0;
	logic                          s_tuser = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [23:0]                   m_tdata;
	logic                          m_tlast;
	logic                          m_tuser;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [fbsc_pkg::ApbAddrW-1:0] paddr = '0;
	logic [31:0]                   pwdata = '0;
	logic [31:0]                   prdata;
	logic                          pready;

	int   fail_cnt;
	int   pending;
	int   req_cnt;
	int   res_cnt;
	logic steady = 1'b0;
	logic hold_req = 1'b0;
	int   hold_left = 0;
	int   stall_cycles = 0;
	int   frame_cnt = 0;

	frame_byte_stuffing_codec_top dut (.*);

	fbsc_stream_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random back-pressure, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HoldCycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= IdlePct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
					(psel && penable && pwrite && pready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= StallLimit) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic send_req(input logic [7:0] b, input logic first, input logic last);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IdlePct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= first;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	// let every expected result out, then allow for a request that yields nothing
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_mode(input logic m);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ModeAddr;
		pwdata  <= {31'($urandom_range(32'h7FFF_FFFF)), m};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// escape codes turn up far more often than chance would give
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return fbsc_pkg::EscCode;
			1: return fbsc_pkg::DelimCode;
			2: return fbsc_pkg::EscOfDelim;
			3: return fbsc_pkg::EscOfEsc;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_frame(input int inner);
		send_req(8'($urandom_range(255)), 1'b1, 1'b0);
		repeat (inner) send_req(pick_byte(), 1'b0, 1'b0);
		send_req(pick_byte(), 1'b0, 1'b1);
		frame_cnt++;
	endtask

	task automatic random_phase(input logic m, input int n_reqs);
		int start;
		int pick;
		int len;
		start = req_cnt;
		drain();
		write_mode(m);
		while (req_cnt - start < n_reqs) begin
			pick = $urandom_range(99);
			len  = ($urandom_range(19) == 0) ? $urandom_range(40, 20) : $urandom_range(10);
			if (pick < 85) begin
				send_frame(len);
			end else if (pick < 93) begin
				send_req(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
			end else begin
				// opened frame that is never closed
				send_req(pick_byte(), 1'b1, 1'b0);
				repeat (len) send_req(pick_byte(), 1'b0, 1'b0);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// stuffing: both escape codes inside, extremes, escape code as last byte
		write_mode(fbsc_pkg::ModeStuff);
		send_req(8'hFF, 1'b1, 1'b0);
		send_req(fbsc_pkg::EscCode, 1'b0, 1'b0);
		send_req(fbsc_pkg::DelimCode, 1'b0, 1'b0);
		send_req(8'h00, 1'b0, 1'b0);
		send_req(8'hFF, 1'b0, 1'b0);
		send_req(fbsc_pkg::EscOfEsc, 1'b0, 1'b0);
		send_req(fbsc_pkg::EscOfDelim, 1'b0, 1'b0);
		send_req(fbsc_pkg::EscCode, 1'b0, 1'b1);
		send_req(8'h00, 1'b1, 1'b1);
		// bytes with no frame open
		send_req(8'h33, 1'b0, 1'b0);
		send_req(fbsc_pkg::DelimCode, 1'b0, 1'b0);
		drain();

		// unstuffing: every pair, held escape at the last byte, held escape under a first mark
		write_mode(fbsc_pkg::ModeUnstuff);
		send_req(8'h00, 1'b1, 1'b0);
		send_req(fbsc_pkg::EscCode, 1'b0, 1'b0);
		send_req(fbsc_pkg::EscOfDelim, 1'b0, 1'b0);
		send_req(fbsc_pkg::EscCode, 1'b0, 1'b0);
		send_req(fbsc_pkg::EscOfEsc, 1'b0, 1'b0);
		send_req(fbsc_pkg::EscCode, 1'b0, 1'b0);
		send_req(8'h77, 1'b0, 1'b0);
		send_req(fbsc_pkg::EscCode, 1'b0, 1'b0);
		send_req(fbsc_pkg::EscCode, 1'b0, 1'b0);
		send_req(8'h41, 1'b0, 1'b0);
		send_req(fbsc_pkg::EscCode, 1'b0, 1'b0);
		send_req(fbsc_pkg::EscOfDelim, 1'b0, 1'b1);
		send_req(fbsc_pkg::EscCode, 1'b1, 1'b0);
		send_req(fbsc_pkg::EscCode, 1'b0, 1'b0);
		send_req(fbsc_pkg::EscOfEsc, 1'b0, 1'b1);
		send_req(fbsc_pkg::EscCode, 1'b0, 1'b0);
		send_req(8'hEE, 1'b0, 1'b1);
		send_req(fbsc_pkg::EscCode, 1'b0, 1'b0);
		send_req(8'hFF, 1'b1, 1'b1);
		send_req(fbsc_pkg::EscCode, 1'b0, 1'b1);
		// leave an escape held, then switch to stuffing under it
		send_req(fbsc_pkg::EscCode, 1'b0, 1'b0);
		drain();
		write_mode(fbsc_pkg::ModeStuff);
		send_req(fbsc_pkg::EscOfDelim, 1'b0, 1'b0);
		send_req(8'h11, 1'b0, 1'b1);

		random_phase(fbsc_pkg::ModeStuff, 110);
		random_phase(fbsc_pkg::ModeUnstuff, 20);
		hold_req = 1'b1;
		random_phase(fbsc_pkg::ModeUnstuff, 100);
		steady = 1'b1;
		random_phase(fbsc_pkg::ModeStuff, 120);
		steady = 1'b0;
		random_phase(fbsc_pkg::ModeUnstuff, 120);
		random_phase(fbsc_pkg::ModeStuff, 100);
		random_phase(fbsc_pkg::ModeUnstuff, 100);

		drain();
		repeat (20) @(negedge clk);
		if (pending != 0)
			$error("%0d expected results never arrived", pending);
		$display("summary: %0d requests (%0d random frames) in both modes, %0d results checked",
			req_cnt, frame_cnt, res_cnt);
		$display("summary: directed escape cases, long receiver hold-off and idle-free stretch");
		if (fail_cnt == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== frame_byte_stuffing_codec_top.f =====
+incdir+sv
sv/fbsc_pkg.sv
sv/fbsc_decode.sv
sv/fbsc_outbuf.sv
sv/frame_byte_stuffing_codec_top.sv
tb/fbsc_stream_checker.sv
tb/tb_frame_byte_stuffing_codec_top.sv
